// ----- hw/rtl/fgsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsc_pkg
// Shared constants and types of the fuel gauge SOC compensator.
// ----------------------------------------------------------------------------
package fgsc_pkg;

    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 88;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    localparam int DIV_NUM_W = 22;
    localparam int DIV_DEN_W = 14;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int FULL_MARGIN = 100;
    localparam int FULL_MAX    = 10000;

    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_FULL    = 2'd1;
    localparam logic [1:0] MODE_TEMP    = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam logic [1:0] CS_CHARGING     = 2'd0;
    localparam logic [1:0] CS_DISCHARGING  = 2'd1;
    localparam logic [1:0] CS_NOT_CHARGING = 2'd2;

    localparam logic       HEALTH_GOOD = 1'b0;
    localparam logic       HEALTH_DEAD = 1'b1;

    localparam logic [1:0] LEVEL_NORMAL   = 2'd0;
    localparam logic [1:0] LEVEL_FULL     = 2'd1;
    localparam logic [1:0] LEVEL_CRITICAL = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_POINT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_BASE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_TEMP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RCOMP_CHG    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RCOMP_DIS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALERT_THRESH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_THRESH  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESH   = 3'd7;

    typedef struct packed {
        logic [13:0]        empty_point;
        logic [13:0]        full_point_base;
        logic signed [8:0]  reference_temp;
        logic [7:0]         rcomp_charging;
        logic [7:0]         rcomp_discharging;
        logic [4:0]         alert_threshold;
        logic [6:0]         full_threshold;
        logic [6:0]         low_threshold;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [13:0] value;
    } full_load_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hw/rtl/fgsc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsc_cfg_regs
// Configuration register file; flags a reload of the learned full point.
// ----------------------------------------------------------------------------
module fgsc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [fgsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fgsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output fgsc_pkg::cfg_t                    cfg,
    output fgsc_pkg::full_load_t              full_load
);

    fgsc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.empty_point       <= 14'd0;
            cfg_reg.full_point_base   <= 14'd10000;
            cfg_reg.reference_temp    <= 9'sd20;
            cfg_reg.rcomp_charging    <= 8'd215;
            cfg_reg.rcomp_discharging <= 8'd215;
            cfg_reg.alert_threshold   <= 5'd0;
            cfg_reg.full_threshold    <= 7'd99;
            cfg_reg.low_threshold     <= 7'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                fgsc_pkg::REG_EMPTY_POINT:
                    cfg_reg.empty_point       <= cfg_wdata[13:0];
                fgsc_pkg::REG_FULL_BASE:
                    cfg_reg.full_point_base   <= cfg_wdata[13:0];
                fgsc_pkg::REG_REF_TEMP:
                    cfg_reg.reference_temp    <= $signed(cfg_wdata[8:0]);
                fgsc_pkg::REG_RCOMP_CHG:
                    cfg_reg.rcomp_charging    <= cfg_wdata[7:0];
                fgsc_pkg::REG_RCOMP_DIS:
                    cfg_reg.rcomp_discharging <= cfg_wdata[7:0];
                fgsc_pkg::REG_ALERT_THRESH:
                    cfg_reg.alert_threshold   <= cfg_wdata[4:0];
                fgsc_pkg::REG_FULL_THRESH:
                    cfg_reg.full_threshold    <= cfg_wdata[6:0];
                fgsc_pkg::REG_LOW_THRESH:
                    cfg_reg.low_threshold     <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // Writing the full base also reloads the learned point, saturated to full scale
    assign full_load.load  = cfg_we && (cfg_index == fgsc_pkg::REG_FULL_BASE);
    assign full_load.value = (cfg_wdata[13:0] > 14'(fgsc_pkg::FULL_MAX))
                           ? 14'(fgsc_pkg::FULL_MAX) : cfg_wdata[13:0];

endmodule

// ----- hw/rtl/fgsc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgsc_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  fgsc_pkg::div_req_t req,
    output fgsc_pkg::div_rsp_t rsp
);

    localparam int NW = fgsc_pkg::DIV_NUM_W;
    localparam int DW = fgsc_pkg::DIV_DEN_W;
    localparam int CW = fgsc_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quot_reg;
    logic [NW-1:0] quot_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [DW:0]   shifted;

    always_comb begin
        shifted = {rem_reg, quot_reg[NW-1]};
        if (shifted >= {1'b0, den_reg}) begin
            rem_next  = DW'(shifted - {1'b0, den_reg});
            quot_next = {quot_reg[NW-2:0], 1'b1};
        end else begin
            rem_next  = shifted[DW-1:0];
            quot_next = {quot_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            den_reg  <= req.divisor;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ----- hw/rtl/fuel_gauge_soc_compensator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuel_gauge_soc_compensator
// Battery gauge post-processing: SOC rescale, status, full relearn, RCOMP.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream (tuser carries the mode), one result
// item per input leaves on the m_ stream. The user writes registers through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not check it.
// Each item is worked by a small sequencer around one shared restoring
// divider that yields one quotient bit per cycle:
//   sample and full event: one divider pass,
//   temperature update: two divider passes (one when the temperature
//   lies below the reference), ignored mode or a bad divisor in sample
//   mode: no divider pass.
// The divider loop sets the rate; one item is in flight at a time and
// s_tready is high only in the idle state.
// Results sit in an output register, so the next item is taken while a
// result still waits; a stalled receiver holds the finishing item until the
// pending result is transferred.
// Reset restores the register defaults, sets the learned full point to
// 10000, clears the previous-sample history and empties the output.
// ----------------------------------------------------------------------------
module fuel_gauge_soc_compensator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // soc_word, vcell_word, charger_present, charger_active, temp_tenths,
    // is_charging
    input  logic [fgsc_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode
    input  logic [fgsc_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // soc_percent, raw_soc_hundredths, cell_microvolts, charge_state,
    // health_code, level_code, changed, learned_full, config_word,
    // divide_fault, zero fill
    output logic [fgsc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [fgsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fgsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MID  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    typedef struct packed {
        logic        divide_fault;
        logic [15:0] config_word;
        logic [13:0] learned_full;
        logic        changed;
        logic [1:0]  level_code;
        logic        health_code;
        logic [1:0]  charge_state;
        logic [22:0] cell_microvolts;
        logic [14:0] raw_soc_hundredths;
        logic [6:0]  soc_percent;
    } out_t;

    fgsc_pkg::cfg_t       cfg;
    fgsc_pkg::full_load_t full_load;
    fgsc_pkg::div_req_t   div_req;
    fgsc_pkg::div_rsp_t   div_rsp;

    state_t state_reg;
    state_t state_next;

    // captured item
    logic [1:0]         mode_reg;
    logic [15:0]        soc_word_reg;
    logic [11:0]        vcell_reg;
    logic               present_reg;
    logic               active_reg;
    logic signed [11:0] temp_reg;
    logic               is_chg_reg;

    // working values
    logic [14:0]        raw_reg;
    logic [22:0]        uv_reg;
    logic signed [15:0] t_reg;
    logic               neg_reg;
    logic               second_reg;
    logic [7:0]         r_reg;
    logic               div_start_reg;
    logic [21:0]        div_num_reg;
    logic [13:0]        div_den_reg;

    // persistent state
    logic [13:0]        full_learned_reg;
    logic [14:0]        last_raw_reg;
    logic [22:0]        prev_uv_reg;
    logic [6:0]         prev_soc_reg;
    logic [1:0]         prev_cs_reg;

    out_t               out_reg;
    logic               m_tvalid_reg;

    logic               accept;
    logic               fin_go;

    fgsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .full_load (full_load)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_num_reg;
    assign div_req.divisor  = div_den_reg;

    fgsc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    // ---------------- prep: raw conversions and full-event target
    logic [22:0]        raw_prod;
    logic [22:0]        uv_prod;
    logic signed [15:0] lim_s;
    logic signed [15:0] t_prep;

    always_comb begin
        raw_prod = 23'(soc_word_reg) * 23'd100;
        uv_prod  = 23'(vcell_reg) * 23'd1250;
        lim_s    = $signed({2'b00, cfg.full_point_base})
                 - $signed(16'(fgsc_pkg::FULL_MARGIN));
        if ($signed({1'b0, last_raw_reg}) > lim_s) begin
            t_prep = (last_raw_reg > 15'(fgsc_pkg::FULL_MAX))
                   ? $signed(16'(fgsc_pkg::FULL_MAX)) : $signed({1'b0, last_raw_reg});
        end else begin
            t_prep = lim_s;
        end
    end

    // ---------------- load: dividend and divisor per mode
    logic signed [14:0] den_s;
    logic               fault;
    logic signed [15:0] diff0;
    logic signed [22:0] prod0;
    logic signed [16:0] diff1;
    logic signed [23:0] prod1;
    logic [11:0]        temp_abs;

    always_comb begin
        den_s    = $signed({1'b0, full_learned_reg}) - $signed({1'b0, cfg.empty_point});
        fault    = den_s[14] || (den_s == 15'sd0);
        diff0    = $signed({1'b0, raw_reg}) - $signed({2'b00, cfg.empty_point});
        prod0    = $signed({{7{diff0[15]}}, diff0}) * 23'sd100;
        diff1    = $signed({t_reg[15], t_reg}) - $signed({3'b000, cfg.empty_point});
        prod1    = $signed({{7{diff1[16]}}, diff1}) * 24'sd99;
        temp_abs = temp_reg[11] ? 12'(-temp_reg) : temp_reg;
    end

    // ---------------- mid: first temperature pass done
    logic [7:0]         base_rc;
    logic signed [9:0]  t_deg;
    logic signed [9:0]  ref_deg;
    logic signed [10:0] d_s;
    logic [11:0]        r_up;
    logic [10:0]        q_temp;

    always_comb begin
        base_rc = is_chg_reg ? cfg.rcomp_charging : cfg.rcomp_discharging;
        t_deg   = neg_reg ? -$signed({2'b00, div_rsp.quotient[7:0]})
                          :  $signed({2'b00, div_rsp.quotient[7:0]});
        ref_deg = $signed({cfg.reference_temp[8], cfg.reference_temp});
        d_s     = $signed({ref_deg[9], ref_deg}) - $signed({t_deg[9], t_deg});
        r_up    = 12'(base_rc) + 12'(d_s[9:0]) * 12'd5;
        q_temp  = div_rsp.quotient[10:0];
    end

    // ---------------- fin: result assembly
    logic [21:0]        q;
    logic [6:0]         soc;
    logic               health;
    logic [1:0]         level;
    logic [1:0]         cs;
    logic               chg;
    logic signed [16:0] learn_s;
    logic [13:0]        learn_sat;
    logic [7:0]         r_fin;
    out_t               out_next;

    always_comb begin
        q = div_rsp.quotient;
        if (fault || neg_reg) begin
            soc = 7'd0;
        end else if (q > 22'd100) begin
            soc = 7'd100;
        end else if (raw_reg < 15'd100) begin
            soc = 7'd0;
        end else begin
            soc = q[6:0];
        end

        if (soc > cfg.full_threshold) begin
            health = fgsc_pkg::HEALTH_GOOD;
            level  = fgsc_pkg::LEVEL_FULL;
        end else if (soc < cfg.low_threshold) begin
            health = fgsc_pkg::HEALTH_DEAD;
            level  = fgsc_pkg::LEVEL_CRITICAL;
        end else begin
            health = fgsc_pkg::HEALTH_GOOD;
            level  = fgsc_pkg::LEVEL_NORMAL;
        end

        cs  = present_reg ? (active_reg ? fgsc_pkg::CS_CHARGING : fgsc_pkg::CS_NOT_CHARGING)
                          : fgsc_pkg::CS_DISCHARGING;
        chg = (uv_reg != prev_uv_reg) || (soc != prev_soc_reg) || (cs != prev_cs_reg);

        learn_s = neg_reg ? $signed({3'b000, cfg.empty_point}) - $signed({2'b00, q[14:0]})
                          : $signed({3'b000, cfg.empty_point}) + $signed({2'b00, q[14:0]});
        if (learn_s[16]) begin
            learn_sat = 14'd0;
        end else if (learn_s > $signed(17'(fgsc_pkg::FULL_MAX))) begin
            learn_sat = 14'(fgsc_pkg::FULL_MAX);
        end else begin
            learn_sat = learn_s[13:0];
        end

        if (!second_reg) begin
            r_fin = r_reg;
        end else if (q_temp > {3'b000, base_rc}) begin
            r_fin = 8'd0;
        end else begin
            r_fin = 8'(11'(base_rc) - q_temp);
        end

        out_next = '0;
        out_next.learned_full = full_learned_reg;
        case (mode_reg)
            fgsc_pkg::MODE_SAMPLE: begin
                out_next.soc_percent        = soc;
                out_next.raw_soc_hundredths = raw_reg;
                out_next.cell_microvolts    = uv_reg;
                out_next.charge_state       = cs;
                out_next.health_code        = health;
                out_next.level_code         = level;
                out_next.changed            = chg;
                out_next.divide_fault       = fault;
            end
            fgsc_pkg::MODE_FULL: begin
                out_next.learned_full = learn_sat;
            end
            fgsc_pkg::MODE_TEMP: begin
                out_next.config_word = {r_fin, 3'b000, cfg.alert_threshold};
            end
            default: ;
        endcase
    end

    // ---------------- sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_PREP;
            ST_PREP: state_next = ST_LOAD;
            ST_LOAD: begin
                case (mode_reg)
                    fgsc_pkg::MODE_SAMPLE: state_next = fault ? ST_FIN : ST_DIV;
                    fgsc_pkg::MODE_FULL,
                    fgsc_pkg::MODE_TEMP:   state_next = ST_DIV;
                    default:               state_next = ST_FIN;
                endcase
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = (mode_reg == fgsc_pkg::MODE_TEMP && !second_reg)
                               ? ST_MID : ST_FIN;
                end
            end
            ST_MID:  state_next = (t_deg < ref_deg) ? ST_FIN : ST_DIV;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            div_start_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            full_learned_reg <= 14'(fgsc_pkg::FULL_MAX);
            last_raw_reg     <= '0;
            prev_uv_reg      <= '0;
            prev_soc_reg     <= '0;
            prev_cs_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= ((state_reg == ST_LOAD) && (state_next == ST_DIV))
                          || ((state_reg == ST_MID) && (state_next == ST_DIV));
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (full_load.load) begin
                full_learned_reg <= full_load.value;
            end else if (fin_go && mode_reg == fgsc_pkg::MODE_FULL) begin
                full_learned_reg <= learn_sat;
            end
            if (fin_go && mode_reg == fgsc_pkg::MODE_SAMPLE) begin
                last_raw_reg <= raw_reg;
                if (chg) begin
                    prev_uv_reg  <= uv_reg;
                    prev_soc_reg <= soc;
                    prev_cs_reg  <= cs;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg     <= s_tuser[1:0];
            soc_word_reg <= s_tdata[15:0];
            vcell_reg    <= s_tdata[31:20];
            present_reg  <= s_tdata[32];
            active_reg   <= s_tdata[33];
            temp_reg     <= $signed(s_tdata[45:34]);
            is_chg_reg   <= s_tdata[46];
        end
        if (state_reg == ST_PREP) begin
            raw_reg    <= raw_prod[22:8];
            uv_reg     <= uv_prod;
            t_reg      <= t_prep;
            second_reg <= 1'b0;
        end
        if (state_reg == ST_LOAD) begin
            case (mode_reg)
                fgsc_pkg::MODE_SAMPLE: begin
                    neg_reg     <= prod0[22];
                    div_num_reg <= prod0[22] ? 22'(-prod0) : prod0[21:0];
                    div_den_reg <= den_s[13:0];
                end
                fgsc_pkg::MODE_FULL: begin
                    neg_reg     <= prod1[23];
                    div_num_reg <= prod1[23] ? 22'(-prod1) : prod1[21:0];
                    div_den_reg <= 14'd100;
                end
                fgsc_pkg::MODE_TEMP: begin
                    neg_reg     <= temp_reg[11];
                    div_num_reg <= 22'(temp_abs);
                    div_den_reg <= 14'd10;
                end
                default: ;
            endcase
        end
        if (state_reg == ST_MID) begin
            if (t_deg < ref_deg) begin
                r_reg <= (r_up > 12'd255) ? 8'd255 : r_up[7:0];
            end else begin
                // second pass: 22 * (t - ref) / 10
                neg_reg     <= 1'b0;
                second_reg  <= 1'b1;
                div_num_reg <= 22'(10'(-d_s)) * 22'd22;
                div_den_reg <= 14'd10;
            end
        end
        if (fin_go) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, out_reg};

    // ---------------- checks
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer accepted while an item is in work");

    a_soc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_reg.soc_percent <= 7'd100)
        else $error("compensated soc out of range");

    a_learned_range: assert property (@(posedge aclk) disable iff (!aresetn)
        full_learned_reg <= 14'd10000)
        else $error("learned full point above full scale");

endmodule
